FILE: rtl/core/rcaa_pkg.sv
// Shared types, register codes and constants for the RC autonomy arming logic.
`timescale 1ns / 1ps

package rcaa_pkg;

	localparam int unsigned FREQ_W = 10;
	localparam int unsigned DUTY_W = 14;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 14;

	// hold time before arming, in ms
	localparam logic [TIME_W-1:0] HOLD_MS = 32'd3000;

	// 10*d and d_def + 9*d_lim both fit in 18 bits for 14-bit duties
	localparam int unsigned SCALE_W = 18;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_FREQUENCY        = 3'd0,
		CFG_BRAKE_DEFAULT_DUTY   = 3'd1,
		CFG_BRAKE_MAX_DUTY       = 3'd2,
		CFG_AUX4_DEFAULT_DUTY    = 3'd3,
		CFG_AUX4_MIN_DUTY        = 3'd4,
		CFG_SWITCH5_DEFAULT_DUTY = 3'd5,
		CFG_GEAR_DEFAULT_DUTY    = 3'd6,
		CFG_GEAR_MAX_DUTY        = 3'd7
	} rcaa_cfg_idx_t;

	typedef struct packed {
		logic [FREQ_W-1:0] min_frequency;
		logic [DUTY_W-1:0] brake_default_duty;
		logic [DUTY_W-1:0] brake_max_duty;
		logic [DUTY_W-1:0] aux4_default_duty;
		logic [DUTY_W-1:0] aux4_min_duty;
		logic [DUTY_W-1:0] switch5_default_duty;
		logic [DUTY_W-1:0] gear_default_duty;
		logic [DUTY_W-1:0] gear_max_duty;
	} rcaa_cfg_t;

	localparam rcaa_cfg_t CFG_RESET = '{
		min_frequency:        10'd40,
		brake_default_duty:   14'd750,
		brake_max_duty:       14'd1000,
		aux4_default_duty:    14'd750,
		aux4_min_duty:        14'd500,
		switch5_default_duty: 14'd750,
		gear_default_duty:    14'd750,
		gear_max_duty:        14'd1000
	};

	// per-sample verdict handed from the comparators to the tracker
	typedef struct packed {
		logic pose;  // sticks in arming pose
		logic fault; // frequency fault or channel 5 above default
	} rcaa_flags_t;

endpackage

FILE: rtl/core/rcaa_ifs.sv
// Valid/ready channel interfaces for receiver samples and arming flags.
`timescale 1ns / 1ps

interface rcaa_sample_if;
	logic                           valid;
	logic                           ready;
	logic [rcaa_pkg::TIME_W-1:0]    time_ms;
	logic [rcaa_pkg::FREQ_W-1:0]    freq_ch1;
	logic [rcaa_pkg::FREQ_W-1:0]    freq_ch2;
	logic [rcaa_pkg::FREQ_W-1:0]    freq_ch3;
	logic [rcaa_pkg::FREQ_W-1:0]    freq_ch4;
	logic [rcaa_pkg::FREQ_W-1:0]    freq_ch5;
	logic [rcaa_pkg::FREQ_W-1:0]    freq_ch6;
	logic [rcaa_pkg::DUTY_W-1:0]    duty_ch2;
	logic [rcaa_pkg::DUTY_W-1:0]    duty_ch4;
	logic [rcaa_pkg::DUTY_W-1:0]    duty_ch5;
	logic [rcaa_pkg::DUTY_W-1:0]    duty_ch6;

	modport source (
		output valid, time_ms, freq_ch1, freq_ch2, freq_ch3, freq_ch4, freq_ch5, freq_ch6,
		output duty_ch2, duty_ch4, duty_ch5, duty_ch6,
		input  ready
	);
	modport sink (
		input  valid, time_ms, freq_ch1, freq_ch2, freq_ch3, freq_ch4, freq_ch5, freq_ch6,
		input  duty_ch2, duty_ch4, duty_ch5, duty_ch6,
		output ready
	);
endinterface

interface rcaa_flag_if;
	logic valid;
	logic ready;
	logic auto_enabled;

	modport source (output valid, auto_enabled, input ready);
	modport sink (input valid, auto_enabled, output ready);
endinterface

FILE: rtl/core/rcaa_cfg.sv
// Configuration register file for the arming thresholds.
`timescale 1ns / 1ps

module rcaa_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rcaa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rcaa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output rcaa_pkg::rcaa_cfg_t               cfg
);

	rcaa_pkg::rcaa_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= rcaa_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (rcaa_pkg::rcaa_cfg_idx_t'(cfg_index))
				rcaa_pkg::CFG_MIN_FREQUENCY: begin
					cfg_q.min_frequency <= cfg_wdata[rcaa_pkg::FREQ_W-1:0];
				end
				rcaa_pkg::CFG_BRAKE_DEFAULT_DUTY:   cfg_q.brake_default_duty   <= cfg_wdata;
				rcaa_pkg::CFG_BRAKE_MAX_DUTY:       cfg_q.brake_max_duty       <= cfg_wdata;
				rcaa_pkg::CFG_AUX4_DEFAULT_DUTY:    cfg_q.aux4_default_duty    <= cfg_wdata;
				rcaa_pkg::CFG_AUX4_MIN_DUTY:        cfg_q.aux4_min_duty        <= cfg_wdata;
				rcaa_pkg::CFG_SWITCH5_DEFAULT_DUTY: cfg_q.switch5_default_duty <= cfg_wdata;
				rcaa_pkg::CFG_GEAR_DEFAULT_DUTY:    cfg_q.gear_default_duty    <= cfg_wdata;
				rcaa_pkg::CFG_GEAR_MAX_DUTY:        cfg_q.gear_max_duty        <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/rcaa_pose.sv
// Threshold comparators: arming pose and disarm fault for one sample.
`timescale 1ns / 1ps

module rcaa_pose (
	input  rcaa_pkg::rcaa_cfg_t             cfg,
	input  logic [rcaa_pkg::FREQ_W-1:0]     freq_ch1,
	input  logic [rcaa_pkg::FREQ_W-1:0]     freq_ch2,
	input  logic [rcaa_pkg::FREQ_W-1:0]     freq_ch3,
	input  logic [rcaa_pkg::FREQ_W-1:0]     freq_ch4,
	input  logic [rcaa_pkg::FREQ_W-1:0]     freq_ch5,
	input  logic [rcaa_pkg::FREQ_W-1:0]     freq_ch6,
	input  logic [rcaa_pkg::DUTY_W-1:0]     duty_ch2,
	input  logic [rcaa_pkg::DUTY_W-1:0]     duty_ch4,
	input  logic [rcaa_pkg::DUTY_W-1:0]     duty_ch5,
	input  logic [rcaa_pkg::DUTY_W-1:0]     duty_ch6,
	output rcaa_pkg::rcaa_flags_t           flags
);

	localparam int unsigned SW = rcaa_pkg::SCALE_W;
	localparam int unsigned DW = rcaa_pkg::DUTY_W;

	logic [SW-1:0] lhs2, rhs2, lhs4, rhs4;
	logic [DW-1:0] dev6, span6;
	logic          ch2_ok, ch4_ok, ch5_ok, ch6_ok, freq_fault;

	always_comb begin
		// 90 % toward the limit, scaled by ten to stay exact
		lhs2 = SW'(duty_ch2) * SW'(10);
		rhs2 = SW'(cfg.brake_default_duty) + SW'(cfg.brake_max_duty) * SW'(9);
		lhs4 = SW'(duty_ch4) * SW'(10);
		rhs4 = SW'(cfg.aux4_default_duty) + SW'(cfg.aux4_min_duty) * SW'(9);
		ch2_ok = lhs2 >= rhs2;
		ch4_ok = lhs4 <= rhs4;
		ch5_ok = duty_ch5 <= cfg.switch5_default_duty;

		// within half the range of default; a negative range never matches
		dev6 = (duty_ch6 >= cfg.gear_default_duty) ? duty_ch6 - cfg.gear_default_duty
		                                           : cfg.gear_default_duty - duty_ch6;
		span6 = cfg.gear_max_duty - cfg.gear_default_duty;
		ch6_ok = (cfg.gear_max_duty >= cfg.gear_default_duty) &&
		         ({dev6, 1'b0} <= {1'b0, span6});

		freq_fault = (freq_ch1 < cfg.min_frequency) || (freq_ch2 < cfg.min_frequency) ||
		             (freq_ch3 < cfg.min_frequency) || (freq_ch4 < cfg.min_frequency) ||
		             (freq_ch5 < cfg.min_frequency) || (freq_ch6 < cfg.min_frequency);

		flags.pose  = ch2_ok && ch4_ok && ch5_ok && ch6_ok;
		flags.fault = freq_fault || !ch5_ok;
	end

endmodule

FILE: rtl/core/rcaa_track.sv
// Input register, hold timer, latched flag and result handshake.
`timescale 1ns / 1ps

module rcaa_track (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rcaa_pkg::TIME_W-1:0]     time_ms,
	input  rcaa_pkg::rcaa_flags_t           flags,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            auto_enabled
);

	logic                          valid_s1;
	logic [rcaa_pkg::TIME_W-1:0]   time_s1;
	rcaa_pkg::rcaa_flags_t         flags_s1;

	logic                          out_valid_q;
	logic                          latched_q;
	logic                          seen_q;
	logic [rcaa_pkg::TIME_W-1:0]   hold_q;

	logic                          adv;
	logic                          restart;
	logic                          arm;
	logic [rcaa_pkg::TIME_W-1:0]   elapsed;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	assign elapsed = time_s1 - hold_q;
	assign restart = !seen_q || !flags_s1.pose;
	assign arm     = !restart && (elapsed > rcaa_pkg::HOLD_MS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			latched_q   <= 1'b0;
			seen_q      <= 1'b0;
			hold_q      <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				seen_q      <= 1'b1;
				if (restart) begin
					hold_q <= time_s1;
				end
				latched_q <= !flags_s1.fault && (latched_q || arm);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			time_s1  <= time_ms;
			flags_s1 <= flags;
		end
	end

	assign out_valid    = out_valid_q;
	assign auto_enabled = latched_q;

	a_fault_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && flags_s1.fault) |=> !latched_q)
		else $error("fault did not clear the autonomy flag");

	a_rise_needs_pose: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(latched_q) |-> $past(adv && flags_s1.pose && !flags_s1.fault && seen_q))
		else $error("autonomy flag set without a held pose");

	a_flag_only_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(latched_q) && $stable(hold_q))
		else $error("tracker state changed without a transaction");

	a_restart_seeds: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && restart) |=> (hold_q == $past(time_s1)) && seen_q)
		else $error("hold start not seeded from the sample time");

endmodule

FILE: rtl/core/rc_autonomy_arming_logic.sv
// Top level of the RC autonomy arming logic.
// A sample transaction is registered in the input stage, then its flag in the result
// register. Throughput: one sample per cycle while the flag channel does not stall;
// the hold timer and flag update once per sample.
// Rate is set by the single tracker stage that owns the hold start and latched flag.
// Reset (arst_n low): registers take their default thresholds, flag and hold start clear.
`timescale 1ns / 1ps

module rc_autonomy_arming_logic (
	input  logic                              clk,
	input  logic                              arst_n,
	rcaa_sample_if.sink                       samples,
	rcaa_flag_if.source                       flags,
	input  logic                              cfg_we,
	input  logic [rcaa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rcaa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	// Threshold registers; the user must write them only while the block is idle (the block
	// does not enforce this), so the comparators may read them directly without a shadow copy.
	rcaa_pkg::rcaa_cfg_t   cfg;
	rcaa_pkg::rcaa_flags_t sample_flags;

	rcaa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Comparators work on the incoming transaction before it is registered,
	// so only two flag bits and the timestamp are carried into the stage.
	// The 90 % and 50 % thresholds are integer-scaled, no rounding.
	rcaa_pose u_pose (
		.cfg      (cfg),
		.freq_ch1 (samples.freq_ch1),
		.freq_ch2 (samples.freq_ch2),
		.freq_ch3 (samples.freq_ch3),
		.freq_ch4 (samples.freq_ch4),
		.freq_ch5 (samples.freq_ch5),
		.freq_ch6 (samples.freq_ch6),
		.duty_ch2 (samples.duty_ch2),
		.duty_ch4 (samples.duty_ch4),
		.duty_ch5 (samples.duty_ch5),
		.duty_ch6 (samples.duty_ch6),
		.flags    (sample_flags)
	);

	// Tracker: registered verdict, modular elapsed time against the hold
	// start, then the latched flag in the result register. The first sample
	// only seeds the hold start. A waiting result stalls the input stage once
	// it holds a sample; while that stage is empty one more sample can enter.
	rcaa_track u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (samples.valid),
		.in_ready     (samples.ready),
		.time_ms      (samples.time_ms),
		.flags        (sample_flags),
		.out_valid    (flags.valid),
		.out_ready    (flags.ready),
		.auto_enabled (flags.auto_enabled)
	);

endmodule
